/* rtl/sid_pkg.sv */
// Shared types, decode tables and helper functions of the 8086 subset instruction decoder.
`default_nettype none

package sid_pkg;

	// Depth of the queue between the decode front end and the output back end.
	localparam int unsigned QUEUE_DEPTH = 2;

	// Number of single-byte opcode patterns and two-byte opcode patterns.
	localparam int unsigned NUM_SINGLE = 28;
	localparam int unsigned NUM_DOUBLE = 4;

	// Instruction forms.
	localparam logic [2:0] FORM_IMM_REG = 3'd0;
	localparam logic [2:0] FORM_REGMEM  = 3'd1;
	localparam logic [2:0] FORM_IMM_ACC = 3'd2;
	localparam logic [2:0] FORM_JUMP    = 3'd3;
	localparam logic [2:0] FORM_IMM_RM  = 3'd4;

	// ModRM field codes that steer the displacement size.
	localparam logic [1:0] MOD_MEM_NO_DISP = 2'd0;
	localparam logic [1:0] MOD_MEM_DISP8   = 2'd1;
	localparam logic [1:0] MOD_MEM_DISP16  = 2'd2;
	localparam logic [2:0] RM_DIRECT       = 3'd6;

	// Mnemonic codes, jumps in decode table order.
	typedef enum logic [4:0] {
		OP_MOV, OP_ADD, OP_SUB, OP_CMP,
		OP_JNZ, OP_JL, OP_JLE, OP_JB, OP_JBE, OP_JP, OP_JO, OP_JS,
		OP_JNL, OP_JG, OP_JNB, OP_JA, OP_JNP, OP_JNO, OP_JNS,
		OP_LOOP, OP_LOOPZ, OP_LOOPNZ, OP_JCXZ, OP_JZ
	} op_t;

	// Decode phase of the front end.
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SECOND,
		PH_MODRM,
		PH_DISP,
		PH_IMM,
		PH_JUMP
	} phase_t;

	typedef struct packed {
		logic [7:0] mask;
		logic [7:0] value;
		op_t        op;
		logic [2:0] form;
	} single_pat_t;

	typedef struct packed {
		logic [15:0] mask;
		logic [15:0] value;
		op_t         op;
	} double_pat_t;

	typedef struct packed {
		logic       hit;
		op_t        op;
		logic [2:0] form;
	} single_match_t;

	typedef struct packed {
		logic hit;
		op_t  op;
	} double_match_t;

	// Partly decoded instruction handed from the front end to the back end.
	typedef struct packed {
		logic [4:0]  op;
		logic [2:0]  form;
		logic [7:0]  first_byte;
		logic [7:0]  modrm_byte;
		logic [15:0] disp;
		logic [15:0] imm;
		logic        err;
	} sid_raw_t;

	// Decoded instruction record on the output channel.
	typedef struct packed {
		logic [4:0]  operation;
		logic [2:0]  form;
		logic        wide;
		logic        to_register;
		logic        sign_extend;
		logic [2:0]  reg_field;
		logic [1:0]  mod_field;
		logic [2:0]  rm_field;
		logic [1:0]  disp_bytes;
		logic [15:0] displacement;
		logic [15:0] immediate;
		logic        error;
	} sid_rec_t;

	// Single-byte opcode patterns; the first match in this order wins.
	localparam single_pat_t SINGLE_PATS [NUM_SINGLE] = '{
		'{mask: 8'hF0, value: 8'hB0, op: OP_MOV,    form: FORM_IMM_REG},
		'{mask: 8'hFC, value: 8'h88, op: OP_MOV,    form: FORM_REGMEM},
		'{mask: 8'hFE, value: 8'h04, op: OP_ADD,    form: FORM_IMM_ACC},
		'{mask: 8'hFC, value: 8'h00, op: OP_ADD,    form: FORM_REGMEM},
		'{mask: 8'hFE, value: 8'h2C, op: OP_SUB,    form: FORM_IMM_ACC},
		'{mask: 8'hFC, value: 8'h28, op: OP_SUB,    form: FORM_REGMEM},
		'{mask: 8'hFE, value: 8'h3C, op: OP_CMP,    form: FORM_IMM_ACC},
		'{mask: 8'hFC, value: 8'h38, op: OP_CMP,    form: FORM_REGMEM},
		'{mask: 8'hFF, value: 8'h75, op: OP_JNZ,    form: FORM_JUMP},
		'{mask: 8'hFF, value: 8'h7C, op: OP_JL,     form: FORM_JUMP},
		'{mask: 8'hFF, value: 8'h7E, op: OP_JLE,    form: FORM_JUMP},
		'{mask: 8'hFF, value: 8'h72, op: OP_JB,     form: FORM_JUMP},
		'{mask: 8'hFF, value: 8'h76, op: OP_JBE,    form: FORM_JUMP},
		'{mask: 8'hFF, value: 8'h7A, op: OP_JP,     form: FORM_JUMP},
		'{mask: 8'hFF, value: 8'h70, op: OP_JO,     form: FORM_JUMP},
		'{mask: 8'hFF, value: 8'h78, op: OP_JS,     form: FORM_JUMP},
		'{mask: 8'hFF, value: 8'h7D, op: OP_JNL,    form: FORM_JUMP},
		'{mask: 8'hFF, value: 8'h7F, op: OP_JG,     form: FORM_JUMP},
		'{mask: 8'hFF, value: 8'h73, op: OP_JNB,    form: FORM_JUMP},
		'{mask: 8'hFF, value: 8'h77, op: OP_JA,     form: FORM_JUMP},
		'{mask: 8'hFF, value: 8'h7B, op: OP_JNP,    form: FORM_JUMP},
		'{mask: 8'hFF, value: 8'h71, op: OP_JNO,    form: FORM_JUMP},
		'{mask: 8'hFF, value: 8'h79, op: OP_JNS,    form: FORM_JUMP},
		'{mask: 8'hFF, value: 8'hE2, op: OP_LOOP,   form: FORM_JUMP},
		'{mask: 8'hFF, value: 8'hE1, op: OP_LOOPZ,  form: FORM_JUMP},
		'{mask: 8'hFF, value: 8'hE0, op: OP_LOOPNZ, form: FORM_JUMP},
		'{mask: 8'hFF, value: 8'hE3, op: OP_JCXZ,   form: FORM_JUMP},
		'{mask: 8'hFF, value: 8'h74, op: OP_JZ,     form: FORM_JUMP}
	};

	// Two-byte patterns of the immediate-to-register/memory form.
	localparam double_pat_t DOUBLE_PATS [NUM_DOUBLE] = '{
		'{mask: 16'hFE38, value: 16'hC600, op: OP_MOV},
		'{mask: 16'hFC38, value: 16'h8000, op: OP_ADD},
		'{mask: 16'hFC38, value: 16'h8028, op: OP_SUB},
		'{mask: 16'hFC38, value: 16'h8038, op: OP_CMP}
	};

	// First matching single-byte pattern, scanned from the end so the lowest entry wins.
	function automatic single_match_t match_single(input logic [7:0] b);
		single_match_t res;
		res = '{hit: 1'b0, op: OP_MOV, form: FORM_IMM_REG};
		for (int i = NUM_SINGLE - 1; i >= 0; i--) begin
			if ((b & SINGLE_PATS[i].mask) == SINGLE_PATS[i].value) begin
				res = '{hit: 1'b1, op: SINGLE_PATS[i].op, form: SINGLE_PATS[i].form};
			end
		end
		return res;
	endfunction

	// First matching two-byte pattern.
	function automatic double_match_t match_double(input logic [15:0] w);
		double_match_t res;
		res = '{hit: 1'b0, op: OP_MOV};
		for (int i = NUM_DOUBLE - 1; i >= 0; i--) begin
			if ((w & DOUBLE_PATS[i].mask) == DOUBLE_PATS[i].value) begin
				res = '{hit: 1'b1, op: DOUBLE_PATS[i].op};
			end
		end
		return res;
	endfunction

	// Displacement bytes implied by a ModRM byte, including the direct address case.
	function automatic logic [1:0] disp_count(input logic [7:0] modrm);
		logic [1:0] cnt;
		case (modrm[7:6])
			MOD_MEM_DISP8:   cnt = 2'd1;
			MOD_MEM_DISP16:  cnt = 2'd2;
			MOD_MEM_NO_DISP: cnt = (modrm[2:0] == RM_DIRECT) ? 2'd2 : 2'd0;
			default:         cnt = 2'd0;
		endcase
		return cnt;
	endfunction

	// Immediate bytes implied by the form and the first opcode byte.
	function automatic logic [1:0] imm_count(input logic [2:0] form, input logic [7:0] fb);
		logic [1:0] cnt;
		case (form)
			FORM_IMM_REG: cnt = fb[3] ? 2'd2 : 2'd1;
			FORM_IMM_ACC: cnt = fb[0] ? 2'd2 : 2'd1;
			FORM_IMM_RM:  cnt = (!fb[1] && fb[0]) ? 2'd2 : 2'd1;
			default:      cnt = 2'd0;
		endcase
		return cnt;
	endfunction

endpackage

`default_nettype wire

/* rtl/sid_byte_if.sv */
// Valid/ready channel that carries one code byte per request.
`default_nettype none

interface sid_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] code_byte;

	modport source (output valid, output code_byte, input ready);
	modport sink (input valid, input code_byte, output ready);
endinterface

`default_nettype wire

/* rtl/sid_rec_if.sv */
// Valid/ready channel that carries one decoded instruction record per request.
`default_nettype none

interface sid_rec_if;
	logic              valid;
	logic              ready;
	sid_pkg::sid_rec_t rec;

	modport source (output valid, output rec, input ready);
	modport sink (input valid, input rec, output ready);
endinterface

`default_nettype wire

/* rtl/sid_front.sv */
// Decode front end: steps through opcode, ModRM, displacement and immediate bytes.
`default_nettype none

module sid_front (
	input  wire logic      clk,
	input  wire logic      arst_n,
	sid_byte_if.sink       code,
	input  wire logic      full,
	output logic           push,
	output sid_pkg::sid_raw_t push_data
);
	import sid_pkg::*;

	phase_t        phase_q, phase_nxt;
	logic [7:0]    first_q, first_nxt;
	logic [7:0]    modrm_q, modrm_nxt;
	logic [15:0]   disp_q, disp_nxt;
	logic [15:0]   imm_q, imm_nxt;
	logic [1:0]    left_q, left_nxt;
	logic [4:0]    op_q, op_nxt;
	logic [2:0]    form_q, form_nxt;
	logic          done;
	logic          err;
	logic          accept;
	logic [7:0]    b;
	single_match_t sm;
	double_match_t dm;
	logic [1:0]    dcnt;
	logic          high_byte;

	// A byte may finish an instruction, so take it only while the queue has room.
	assign code.ready = !full;
	assign accept     = code.valid && code.ready;
	assign b          = code.code_byte;

	assign sm = match_single(b);
	assign dm = match_double({first_q, b});

	// Next decode state for the byte on the input.
	always_comb begin
		phase_nxt = phase_q;
		first_nxt = first_q;
		modrm_nxt = modrm_q;
		disp_nxt  = disp_q;
		imm_nxt   = imm_q;
		left_nxt  = left_q;
		op_nxt    = op_q;
		form_nxt  = form_q;
		done      = 1'b0;
		err       = 1'b0;
		dcnt      = 2'd0;
		high_byte = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				first_nxt = b;
				modrm_nxt = '0;
				disp_nxt  = '0;
				imm_nxt   = '0;
				if (sm.hit) begin
					op_nxt   = sm.op;
					form_nxt = sm.form;
					if (sm.form == FORM_REGMEM) begin
						phase_nxt = PH_MODRM;
					end else if (sm.form == FORM_JUMP) begin
						phase_nxt = PH_JUMP;
					end else begin
						left_nxt  = imm_count(sm.form, b);
						phase_nxt = PH_IMM;
					end
				end else begin
					phase_nxt = PH_SECOND;
				end
			end
			PH_SECOND: begin
				if (dm.hit) begin
					op_nxt    = dm.op;
					form_nxt  = FORM_IMM_RM;
					modrm_nxt = b;
					dcnt      = disp_count(b);
					if (dcnt != 2'd0) begin
						left_nxt  = dcnt;
						phase_nxt = PH_DISP;
					end else begin
						left_nxt  = imm_count(FORM_IMM_RM, first_q);
						phase_nxt = PH_IMM;
					end
				end else begin
					done      = 1'b1;
					err       = 1'b1;
					phase_nxt = PH_IDLE;
				end
			end
			PH_MODRM: begin
				modrm_nxt = b;
				dcnt      = disp_count(b);
				if (dcnt != 2'd0) begin
					left_nxt  = dcnt;
					phase_nxt = PH_DISP;
				end else if (form_q == FORM_IMM_RM) begin
					left_nxt  = imm_count(form_q, first_q);
					phase_nxt = PH_IMM;
				end else begin
					done      = 1'b1;
					phase_nxt = PH_IDLE;
				end
			end
			PH_DISP: begin
				// The second byte of a two-byte field is the high byte.
				high_byte = (left_q == 2'd1) && (disp_count(modrm_q) == 2'd2);
				disp_nxt  = disp_q | (high_byte ? {b, 8'h00} : {8'h00, b});
				left_nxt  = left_q - 2'd1;
				if (left_q == 2'd1) begin
					if (form_q == FORM_IMM_RM) begin
						left_nxt  = imm_count(form_q, first_q);
						phase_nxt = PH_IMM;
					end else begin
						done      = 1'b1;
						phase_nxt = PH_IDLE;
					end
				end
			end
			PH_IMM: begin
				high_byte = (left_q == 2'd1) && (imm_count(form_q, first_q) == 2'd2);
				imm_nxt   = imm_q | (high_byte ? {b, 8'h00} : {8'h00, b});
				left_nxt  = left_q - 2'd1;
				if (left_q == 2'd1) begin
					done      = 1'b1;
					phase_nxt = PH_IDLE;
				end
			end
			PH_JUMP: begin
				imm_nxt   = {{8{b[7]}}, b};
				done      = 1'b1;
				phase_nxt = PH_IDLE;
			end
			default: begin
				phase_nxt = PH_IDLE;
			end
		endcase
	end

	// Hand a finished instruction to the queue.
	assign push = accept && done;
	assign push_data = '{
		op:         op_nxt,
		form:       form_nxt,
		first_byte: first_nxt,
		modrm_byte: modrm_nxt,
		disp:       disp_nxt,
		imm:        imm_nxt,
		err:        err
	};

	// Decode phase register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else if (accept) begin
			phase_q <= phase_nxt;
		end
	end

	// Collected instruction bytes; each is written before it is read.
	always_ff @(posedge clk) begin
		if (accept) begin
			first_q <= first_nxt;
			modrm_q <= modrm_nxt;
			disp_q  <= disp_nxt;
			imm_q   <= imm_nxt;
			left_q  <= left_nxt;
			op_q    <= op_nxt;
			form_q  <= form_nxt;
		end
	end

endmodule

`default_nettype wire

/* rtl/sid_queue.sv */
// Small FIFO between the decode front end and the output back end.
`default_nettype none

module sid_queue #(
	parameter int unsigned DEPTH = sid_pkg::QUEUE_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire sid_pkg::sid_raw_t push_data,
	output logic                   full,
	input  wire logic              pop,
	output sid_pkg::sid_raw_t      pop_data,
	output logic                   not_empty
);
	import sid_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	sid_raw_t           mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_data  = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

/* rtl/sid_back.sv */
// Output back end: expands queued instructions into records and holds the output register.
`default_nettype none

module sid_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sid_pkg::sid_raw_t raw,
	input  wire logic              raw_valid,
	output logic                   pop,
	sid_rec_if.source              decoded
);
	import sid_pkg::*;

	sid_rec_t rec_nxt;
	sid_rec_t rec_q;
	logic     valid_q;
	logic     has_modrm;

	// Refill the output register whenever it is empty or being drained.
	assign pop = raw_valid && (!valid_q || decoded.ready);

	assign decoded.valid = valid_q;
	assign decoded.rec   = rec_q;

	// Field extraction per instruction form.
	always_comb begin
		has_modrm = (raw.form == FORM_REGMEM) || (raw.form == FORM_IMM_RM);
		rec_nxt.operation    = raw.op;
		rec_nxt.form         = raw.form;
		if (raw.form == FORM_IMM_REG) begin
			rec_nxt.wide = raw.first_byte[3];
		end else if (raw.form == FORM_JUMP) begin
			rec_nxt.wide = 1'b0;
		end else begin
			rec_nxt.wide = raw.first_byte[0];
		end
		rec_nxt.to_register  = (raw.form == FORM_REGMEM) ? raw.first_byte[1] : 1'b0;
		rec_nxt.sign_extend  = (raw.form == FORM_IMM_RM) ? raw.first_byte[1] : 1'b0;
		if (raw.form == FORM_IMM_REG) begin
			rec_nxt.reg_field = raw.first_byte[2:0];
		end else if (has_modrm) begin
			rec_nxt.reg_field = raw.modrm_byte[5:3];
		end else begin
			rec_nxt.reg_field = 3'd0;
		end
		rec_nxt.mod_field    = has_modrm ? raw.modrm_byte[7:6] : 2'd0;
		rec_nxt.rm_field     = has_modrm ? raw.modrm_byte[2:0] : 3'd0;
		rec_nxt.disp_bytes   = has_modrm ? disp_count(raw.modrm_byte) : 2'd0;
		rec_nxt.displacement = raw.disp;
		rec_nxt.immediate    = raw.imm;
		rec_nxt.error        = 1'b0;
		// An unmatched opcode pair gives a bare error record.
		if (raw.err) begin
			rec_nxt       = '0;
			rec_nxt.error = 1'b1;
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (decoded.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Output record register.
	always_ff @(posedge clk) begin
		if (pop) begin
			rec_q <= rec_nxt;
		end
	end

endmodule

`default_nettype wire

/* rtl/subset_8086_instruction_decoder_top.sv */
// After its last byte is accepted, a record goes through the queue and then the output register.
// Throughput: one code byte per cycle while the queue has room, set by the front end decode step.
// A full queue stalls bytes; the back end drains one record per cycle into a free output register.
// Reset clears the decode phase, the queue pointers and the output valid flag; data registers
// are not reset.
`default_nettype none

module subset_8086_instruction_decoder_top #(
	parameter int unsigned QUEUE_DEPTH = sid_pkg::QUEUE_DEPTH
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	sid_byte_if.sink   code,
	sid_rec_if.source  decoded
);
	import sid_pkg::*;

	sid_raw_t push_data;
	sid_raw_t pop_data;
	logic     push;
	logic     full;
	logic     pop;
	logic     not_empty;

	// Byte-by-byte decode.
	sid_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.code      (code),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	// Decoupling queue.
	sid_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.not_empty (not_empty)
	);

	// Record formatting and output register.
	sid_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.raw       (pop_data),
		.raw_valid (not_empty),
		.pop       (pop),
		.decoded   (decoded)
	);

endmodule

`default_nettype wire

/* tb/decoder_check_pkg.sv */
// Opcode constants, decode helpers and the record scoreboard for the instruction decoder bench.
package decoder_check_pkg;

	import sid_pkg::*;

	// Opcode bases of the decoded subset.
	localparam logic [7:0] OPC_MOV_IR  = 8'hB0;
	localparam logic [7:0] OPC_MOV_RM  = 8'h88;
	localparam logic [7:0] OPC_ADD_RM  = 8'h00;
	localparam logic [7:0] OPC_SUB_RM  = 8'h28;
	localparam logic [7:0] OPC_CMP_RM  = 8'h38;
	localparam logic [7:0] OPC_ADD_ACC = 8'h04;
	localparam logic [7:0] OPC_SUB_ACC = 8'h2C;
	localparam logic [7:0] OPC_CMP_ACC = 8'h3C;
	localparam logic [7:0] OPC_MOV_IRM = 8'hC6;
	localparam logic [7:0] OPC_ALU_IRM = 8'h80;
	localparam logic [7:0] OPC_JCC     = 8'h70;
	localparam logic [7:0] OPC_LOOPS   = 8'hE0;

	// ModRM reg extensions that select the operation of the immediate-to-register/memory form.
	localparam logic [2:0] EXT_MOV = 3'd0;
	localparam logic [2:0] EXT_ADD = 3'd0;
	localparam logic [2:0] EXT_SUB = 3'd5;
	localparam logic [2:0] EXT_CMP = 3'd7;

	// Number of displacement bytes that follow a ModRM byte.
	function automatic logic [1:0] disp_len(input logic [7:0] modrm);
		if (modrm[7:6] == MOD_MEM_DISP8)
			return 2'd1;
		if (modrm[7:6] == MOD_MEM_DISP16)
			return 2'd2;
		if (modrm[7:6] == MOD_MEM_NO_DISP && modrm[2:0] == RM_DIRECT)
			return 2'd2;
		return 2'd0;
	endfunction

	// Number of immediate bytes for a form, steered by the w and s bits of the opcode.
	function automatic logic [1:0] imm_len(input logic [2:0] form, input logic [7:0] opc);
		case (form)
			FORM_IMM_REG: return opc[3] ? 2'd2 : 2'd1;
			FORM_IMM_ACC: return opc[0] ? 2'd2 : 2'd1;
			FORM_IMM_RM:  return (opc[1:0] == 2'b01) ? 2'd2 : 2'd1;
			default:      return 2'd0;
		endcase
	endfunction

	// Classifies a first opcode byte; returns 0 when it needs a second byte.
	function automatic bit single_decode(input logic [7:0] b, output op_t op,
			output logic [2:0] form);
		bit hit;
		hit = 1'b1;
		op = OP_MOV;
		form = FORM_JUMP;
		casez (b)
			8'b1011_????: form = FORM_IMM_REG;
			8'b1000_10??: form = FORM_REGMEM;
			8'b0000_010?: begin op = OP_ADD; form = FORM_IMM_ACC; end
			8'b0000_00??: begin op = OP_ADD; form = FORM_REGMEM; end
			8'b0010_110?: begin op = OP_SUB; form = FORM_IMM_ACC; end
			8'b0010_10??: begin op = OP_SUB; form = FORM_REGMEM; end
			8'b0011_110?: begin op = OP_CMP; form = FORM_IMM_ACC; end
			8'b0011_10??: begin op = OP_CMP; form = FORM_REGMEM; end
			8'h70: op = OP_JO;
			8'h71: op = OP_JNO;
			8'h72: op = OP_JB;
			8'h73: op = OP_JNB;
			8'h74: op = OP_JZ;
			8'h75: op = OP_JNZ;
			8'h76: op = OP_JBE;
			8'h77: op = OP_JA;
			8'h78: op = OP_JS;
			8'h79: op = OP_JNS;
			8'h7A: op = OP_JP;
			8'h7B: op = OP_JNP;
			8'h7C: op = OP_JL;
			8'h7D: op = OP_JNL;
			8'h7E: op = OP_JLE;
			8'h7F: op = OP_JG;
			8'hE0: op = OP_LOOPNZ;
			8'hE1: op = OP_LOOPZ;
			8'hE2: op = OP_LOOP;
			8'hE3: op = OP_JCXZ;
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

	// Two-byte immediate-to-register/memory opcodes; the reg field of the ModRM picks the operation.
	function automatic bit double_decode(input logic [7:0] opc, input logic [7:0] modrm,
			output op_t op);
		op = OP_MOV;
		if (opc[7:1] == OPC_MOV_IRM[7:1])
			return modrm[5:3] == EXT_MOV;
		if (opc[7:2] == OPC_ALU_IRM[7:2]) begin
			case (modrm[5:3])
				EXT_ADD: begin op = OP_ADD; return 1'b1; end
				EXT_SUB: begin op = OP_SUB; return 1'b1; end
				EXT_CMP: begin op = OP_CMP; return 1'b1; end
				default: return 1'b0;
			endcase
		end
		return 1'b0;
	endfunction

	// Tracks the decode of the byte stream and checks the records in order.
	class decode_scoreboard;
		phase_t     ph;
		op_t        op;
		logic [2:0] form;
		logic [7:0] opc;
		logic [7:0] modrm;
		logic [15:0] disp;
		logic [15:0] imm;
		logic [1:0] left;
		logic [1:0] disp_n;
		logic [1:0] imm_n;
		sid_rec_t   expected_recs[$];
		int         errors;

		function new();
			ph = PH_IDLE;
			op = OP_MOV;
			form = FORM_IMM_REG;
			opc = '0;
			modrm = '0;
			disp = '0;
			imm = '0;
			left = '0;
			disp_n = '0;
			imm_n = '0;
			errors = 0;
		endfunction

		function int pending();
			return expected_recs.size();
		endfunction

		// Queues the record of the instruction just completed.
		function void emit_record();
			sid_rec_t r;
			bit has_modrm;
			has_modrm = (form == FORM_REGMEM || form == FORM_IMM_RM);
			r = '0;
			r.operation = op;
			r.form = form;
			if (form == FORM_IMM_REG)
				r.wide = opc[3];
			else if (form != FORM_JUMP)
				r.wide = opc[0];
			r.to_register = (form == FORM_REGMEM) ? opc[1] : 1'b0;
			r.sign_extend = (form == FORM_IMM_RM) ? opc[1] : 1'b0;
			if (form == FORM_IMM_REG)
				r.reg_field = opc[2:0];
			else if (has_modrm)
				r.reg_field = modrm[5:3];
			if (has_modrm) begin
				r.mod_field = modrm[7:6];
				r.rm_field = modrm[2:0];
				r.disp_bytes = disp_n;
			end
			r.displacement = disp;
			r.immediate = imm;
			expected_recs.push_back(r);
			ph = PH_IDLE;
		endfunction

		function void start_imm();
			imm_n = imm_len(form, opc);
			left = imm_n;
			ph = PH_IMM;
		endfunction

		// After the ModRM byte: displacement, then immediate, or the record right away.
		function void after_modrm();
			disp_n = disp_len(modrm);
			if (disp_n != 0) begin
				left = disp_n;
				ph = PH_DISP;
			end else if (form == FORM_IMM_RM) begin
				start_imm();
			end else begin
				emit_record();
			end
		endfunction

		// Advances the decode by one accepted code byte.
		function void note_byte(logic [7:0] b);
			sid_rec_t err_rec;
			case (ph)
				PH_IDLE: begin
					opc = b;
					modrm = '0;
					disp = '0;
					imm = '0;
					disp_n = '0;
					if (single_decode(b, op, form)) begin
						if (form == FORM_REGMEM)
							ph = PH_MODRM;
						else if (form == FORM_JUMP)
							ph = PH_JUMP;
						else
							start_imm();
					end else begin
						ph = PH_SECOND;
					end
				end
				PH_SECOND: begin
					if (double_decode(opc, b, op)) begin
						form = FORM_IMM_RM;
						modrm = b;
						after_modrm();
					end else begin
						// Unknown opcode pair: an error record and back to idle.
						err_rec = '0;
						err_rec.error = 1'b1;
						expected_recs.push_back(err_rec);
						ph = PH_IDLE;
					end
				end
				PH_MODRM: begin
					modrm = b;
					after_modrm();
				end
				PH_DISP: begin
					if (left == disp_n)
						disp[7:0] = b;
					else
						disp[15:8] = b;
					left = left - 2'd1;
					if (left == 0) begin
						if (form == FORM_IMM_RM)
							start_imm();
						else
							emit_record();
					end
				end
				PH_IMM: begin
					if (left == imm_n)
						imm[7:0] = b;
					else
						imm[15:8] = b;
					left = left - 2'd1;
					if (left == 0)
						emit_record();
				end
				PH_JUMP: begin
					imm = {{8{b[7]}}, b};
					emit_record();
				end
				default: ph = PH_IDLE;
			endcase
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 30)
				$display("[%0t] ERROR: %s", $time, msg);
		endtask

		// Compares one output record with the oldest expected one.
		task check(sid_rec_t got);
			sid_rec_t want;
			string bad;
			if (expected_recs.size() == 0) begin
				report($sformatf("record %h with nothing expected", got));
				return;
			end
			want = expected_recs.pop_front();
			bad = "";
			if (got.operation !== want.operation) bad = {bad, " operation"};
			if (got.form !== want.form) bad = {bad, " form"};
			if (got.wide !== want.wide) bad = {bad, " wide"};
			if (got.to_register !== want.to_register) bad = {bad, " to_register"};
			if (got.sign_extend !== want.sign_extend) bad = {bad, " sign_extend"};
			if (got.reg_field !== want.reg_field) bad = {bad, " reg_field"};
			if (got.mod_field !== want.mod_field) bad = {bad, " mod_field"};
			if (got.rm_field !== want.rm_field) bad = {bad, " rm_field"};
			if (got.disp_bytes !== want.disp_bytes) bad = {bad, " disp_bytes"};
			if (got.displacement !== want.displacement) bad = {bad, " displacement"};
			if (got.immediate !== want.immediate) bad = {bad, " immediate"};
			if (got.error !== want.error) bad = {bad, " error"};
			if (bad != "")
				report($sformatf("field(s)%s differ: got %h, want %h", bad, got, want));
		endtask

		// Any record still expected at the end never came out.
		task flush();
			sid_rec_t want;
			while (expected_recs.size() != 0) begin
				want = expected_recs.pop_front();
				report($sformatf("record %h never came out", want));
			end
		endtask
	endclass

endpackage

/* tb/subset_8086_instruction_decoder_top_tb.sv */
// Top-level bench: drives code bytes, stalls the record channel and checks every decoded record.
module subset_8086_instruction_decoder_top_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import sid_pkg::*;
	import decoder_check_pkg::*;

	localparam int LIMIT = 200000;
	localparam int PHASE_BYTES = 312;

	logic clk;
	logic arst_n;
	int   idle_pct;
	int   stall_pct;
	int   hold_left;
	int   bytes_sent;
	int   cycle_count;

	decode_scoreboard sb;

	sid_byte_if code_ch ();
	sid_rec_if  rec_ch ();

	subset_8086_instruction_decoder_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.code    (code_ch),
		.decoded (rec_ch)
	);

	// Clock, 10 ns period.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT) begin
			$display("subset_8086_instruction_decoder_top: mismatch");
			$finish;
		end
	end

	// Record receiver: a long hold-off when one is armed, otherwise random stalls.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			rec_ch.ready <= 1'b0;
			hold_left--;
		end else begin
			rec_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Watch both channels: feed accepted bytes to the predictor, check accepted records.
	always @(posedge clk) begin
		if (arst_n && code_ch.valid && code_ch.ready)
			sb.note_byte(code_ch.code_byte);
		if (arst_n && rec_ch.valid && rec_ch.ready)
			sb.check(rec_ch.rec);
	end

	// Offers one code byte, after a random idle gap, and waits for the request to be taken.
	task automatic send_byte(input logic [7:0] b);
		int gaps;
		gaps = 0;
		while (gaps < 8 && $urandom_range(0, 99) < idle_pct)
			gaps++;
		if (gaps > 0) begin
			code_ch.valid <= 1'b0;
			repeat (gaps) @(posedge clk);
		end
		code_ch.valid <= 1'b1;
		code_ch.code_byte <= b;
		do @(posedge clk); while (!code_ch.ready);
		bytes_sent++;
	endtask

	task automatic send_seq(input logic [7:0] seq[$]);
		foreach (seq[i])
			send_byte(seq[i]);
	endtask

	// Stops offering bytes until every expected record has come out.
	task automatic drain();
		code_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// Data byte with a bias toward the edges of the range.
	function automatic logic [7:0] rand_data();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h80;
			3: return 8'h7F;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// ModRM byte with the given reg field; the direct address case comes up often.
	function automatic logic [7:0] rand_modrm(input logic [2:0] reg_sel);
		logic [1:0] md;
		logic [2:0] rm;
		md = 2'($urandom_range(0, 3));
		rm = 3'($urandom_range(0, 7));
		if (md == MOD_MEM_NO_DISP && $urandom_range(0, 3) == 0)
			rm = RM_DIRECT;
		return {md, reg_sel, rm};
	endfunction

	// One random instruction: mostly well formed, some bad opcode pairs and raw noise.
	task automatic gen_instruction();
		int kind;
		int pick;
		logic [7:0] seq[$];
		logic [7:0] opc;
		logic [7:0] modrm;
		logic [2:0] reg_sel;
		logic [2:0] form_tmp;
		op_t op_tmp;
		logic [1:0] n_disp;
		logic [1:0] n_imm;
		n_disp = 2'd0;
		n_imm = 2'd0;
		kind = $urandom_range(0, 99);
		if (kind < 12) begin
			opc = OPC_MOV_IR | 8'($urandom_range(0, 15));
			seq.push_back(opc);
			n_imm = imm_len(FORM_IMM_REG, opc);
		end else if (kind < 34) begin
			case ($urandom_range(0, 3))
				0: opc = OPC_MOV_RM;
				1: opc = OPC_ADD_RM;
				2: opc = OPC_SUB_RM;
				default: opc = OPC_CMP_RM;
			endcase
			opc = opc | 8'($urandom_range(0, 3));
			modrm = rand_modrm(3'($urandom_range(0, 7)));
			seq.push_back(opc);
			seq.push_back(modrm);
			n_disp = disp_len(modrm);
		end else if (kind < 44) begin
			case ($urandom_range(0, 2))
				0: opc = OPC_ADD_ACC;
				1: opc = OPC_SUB_ACC;
				default: opc = OPC_CMP_ACC;
			endcase
			opc = opc | 8'($urandom_range(0, 1));
			seq.push_back(opc);
			n_imm = imm_len(FORM_IMM_ACC, opc);
		end else if (kind < 62) begin
			pick = $urandom_range(0, 19);
			opc = (pick < 16) ? OPC_JCC + 8'(pick) : OPC_LOOPS + 8'(pick - 16);
			seq.push_back(opc);
			seq.push_back(rand_data());
		end else if (kind < 82) begin
			if ($urandom_range(0, 3) == 0) begin
				opc = OPC_MOV_IRM | 8'($urandom_range(0, 1));
				reg_sel = EXT_MOV;
			end else begin
				opc = OPC_ALU_IRM | 8'($urandom_range(0, 3));
				case ($urandom_range(0, 2))
					0: reg_sel = EXT_ADD;
					1: reg_sel = EXT_SUB;
					default: reg_sel = EXT_CMP;
				endcase
			end
			modrm = rand_modrm(reg_sel);
			seq.push_back(opc);
			seq.push_back(modrm);
			n_disp = disp_len(modrm);
			n_imm = imm_len(FORM_IMM_RM, opc);
		end else if (kind < 92) begin
			// Opcode pairs that match nothing, or a random first byte that needs a second and a random next byte.
			case ($urandom_range(0, 2))
				0: begin
					opc = OPC_MOV_IRM | 8'($urandom_range(0, 1));
					modrm = rand_modrm(3'($urandom_range(1, 7)));
				end
				1: begin
					opc = OPC_ALU_IRM | 8'($urandom_range(0, 3));
					pick = $urandom_range(1, 5);
					modrm = rand_modrm((pick == 5) ? 3'd6 : 3'(pick));
				end
				default: begin
					do opc = 8'($urandom_range(0, 255));
					while (single_decode(opc, op_tmp, form_tmp));
					modrm = 8'($urandom_range(0, 255));
				end
			endcase
			seq.push_back(opc);
			seq.push_back(modrm);
		end else begin
			// Raw noise; the predictor follows wherever it leaves the decode.
			repeat ($urandom_range(1, 3))
				seq.push_back(8'($urandom_range(0, 255)));
		end
		repeat (n_disp) seq.push_back(rand_data());
		repeat (n_imm) seq.push_back(rand_data());
		send_seq(seq);
	endtask

	initial begin
		logic [7:0] directed_seq[$];
		int idle_tab[4];
		int stall_tab[4];
		int target;
		sb = new();
		code_ch.valid = 1'b0;
		code_ch.code_byte = 8'h00;
		rec_ch.ready = 1'b0;
		arst_n = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		hold_left = 0;
		bytes_sent = 0;
		cycle_count = 0;
		idle_tab = '{0, 52, 0, 25};
		stall_tab = '{0, 0, 52, 25};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every form, displacement size and immediate size, direct addresses,
		// sign-extended immediates, and opcode pairs that match nothing.
		directed_seq = {
			8'hB0, 8'h00,
			8'hBF, 8'hFF, 8'hFF,
			8'h8B, 8'h06, 8'h34, 8'h12,
			8'h89, 8'hC1,
			8'h00, 8'h47, 8'h80,
			8'h2B, 8'h96, 8'hFF, 8'hFF,
			8'h3A, 8'h00,
			8'h05, 8'h34, 8'h12,
			8'h2C, 8'h80,
			8'h3D, 8'hFF, 8'hFF,
			8'hC6, 8'h06, 8'h00, 8'h10, 8'hAB,
			8'hC7, 8'h84, 8'h02, 8'h01, 8'hFF,
			8'h83, 8'hC0, 8'hFF,
			8'h81, 8'h2E, 8'h00, 8'h01, 8'h34, 8'h12,
			8'h82, 8'hF8, 8'h7F,
			8'h80, 8'h08,
			8'hFF, 8'hFF,
			8'h0F, 8'h00,
			8'hC6, 8'h38
		};
		send_seq(directed_seq);

		// Every jump and loop, with offsets at both ends of the signed range.
		for (int i = 0; i < 20; i++) begin
			send_byte((i < 16) ? OPC_JCC + 8'(i) : OPC_LOOPS + 8'(i - 16));
			case (i % 4)
				0: send_byte(8'h00);
				1: send_byte(8'h7F);
				2: send_byte(8'h80);
				default: send_byte(8'hFF);
			endcase
		end
		drain();

		// Random phases with different idling on each side.
		for (int p = 0; p < 4; p++) begin
			idle_pct = idle_tab[p];
			stall_pct = stall_tab[p];
			// Long receiver hold-off while bytes keep coming, so the block backs up.
			if (p == 0)
				hold_left = 300;
			target = bytes_sent + PHASE_BYTES;
			while (bytes_sent < target) begin
				gen_instruction();
				if ($urandom_range(0, 99) == 0)
					drain();
			end
			drain();
		end

		repeat (8) @(posedge clk);
		sb.flush();
		if (sb.errors == 0)
			$display("subset_8086_instruction_decoder_top: match");
		else
			$display("subset_8086_instruction_decoder_top: mismatch");
		$finish;
	end

endmodule

/* sim.f */
rtl/sid_pkg.sv
rtl/sid_byte_if.sv
rtl/sid_rec_if.sv
rtl/sid_front.sv
rtl/sid_queue.sv
rtl/sid_back.sv
rtl/subset_8086_instruction_decoder_top.sv
tb/decoder_check_pkg.sv
tb/subset_8086_instruction_decoder_top_tb.sv
